// ===== rtl/assert_macros.svh =====
// Assertion macros used by dbm_core of the desktop-bus mouse.
// No dependencies; expects clk and rst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define DBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define DBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dbm_pkg.sv =====
// Types, codes and arithmetic helpers for the desktop-bus mouse.
// No dependencies; used by every module of the block.
package dbm_pkg;

    localparam logic [1:0] OP_MOTION = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_BUS    = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;

    // command byte decode
    localparam logic [3:0] CMD_FLUSH   = 4'h1;
    localparam logic [1:0] KIND_LISTEN = 2'b10;
    localparam logic [1:0] KIND_TALK   = 2'b11;
    localparam logic [1:0] REG_0       = 2'd0;
    localparam logic [1:0] REG_3       = 2'd3;

    localparam logic [3:0] LISTEN_LEN   = 4'd3;
    localparam logic [7:0] CODE_SELFTEST = 8'hff;
    localparam logic [7:0] HANDLER_1    = 8'd1;
    localparam logic [7:0] HANDLER_2    = 8'd2;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_TWO  = 2'd2;

    localparam logic [3:0] RESET_ADDRESS = 4'd3;
    localparam logic [7:0] RESET_HANDLER = 8'd2;

    localparam logic signed [15:0] CLAMP_POS = 16'sd63;
    localparam logic signed [15:0] CLAMP_NEG = -16'sd63;
    localparam logic signed [15:0] SAT_MAX   = 16'sh7fff;
    localparam logic signed [15:0] SAT_MIN   = 16'sh8000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        axis;
        logic signed [15:0] move_value;
        logic [1:0]        button_id;
        logic              button_down;
        logic [7:0]        command_byte;
        logic [7:0]        data_first;
        logic [7:0]        data_second;
        logic [3:0]        byte_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] reply_first;
        logic [7:0] reply_second;
        logic [1:0] reply_length;
        logic       data_pending;
        logic [3:0] bus_address;
    } result_t;

    // 16-bit add that sticks at the signed limits
    function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                      input logic signed [15:0] b);
        logic signed [16:0] sum;
        begin
            sum = {a[15], a} + {b[15], b};
            if (sum[16] != sum[15])
                sat_add16 = sum[16] ? SAT_MIN : SAT_MAX;
            else
                sat_add16 = sum[15:0];
        end
    endfunction

    function automatic logic signed [15:0] clamp63(input logic signed [15:0] v);
        begin
            if (v > CLAMP_POS)
                clamp63 = CLAMP_POS;
            else if (v < CLAMP_NEG)
                clamp63 = CLAMP_NEG;
            else
                clamp63 = v;
        end
    endfunction

endpackage

// ===== rtl/desktop_bus_mouse_device.sv =====
// Top level of the desktop-bus mouse: input register, event logic, result register.
// Depends on dbm_pkg, dbm_in_stage, dbm_core and dbm_out_stage.
//
// Takes one beat per clock while the output side is not stalled and gives one
// result beat per input beat, in order. An accepted beat is held in the input
// register; when the result register has room, the motion, button or
// bus-command logic updates the mouse state and its result is loaded into the
// output register, which raises out_valid.
// The sustained rate is one item per cycle unless out_ready stalls, set by the single
// state update each beat performs; the next beat sees the state the previous one left.
module desktop_bus_mouse_device
    import dbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [1:0]        axis,
    input  logic signed [15:0] move_value,
    input  logic [1:0]        button_id,
    input  logic              button_down,
    input  logic [7:0]        command_byte,
    input  logic [7:0]        data_first,
    input  logic [7:0]        data_second,
    input  logic [3:0]        byte_count,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        reply_first,
    output logic [7:0]        reply_second,
    output logic [1:0]        reply_length,
    output logic              data_pending,
    output logic [3:0]        bus_address
);

    in_item_t in_item;
    in_item_t item;
    result_t  res;
    result_t  res_out;
    logic     item_valid;
    logic     room;
    logic     advance;

    always_comb
    begin
        in_item.opcode       = opcode;
        in_item.axis         = axis;
        in_item.move_value   = move_value;
        in_item.button_id    = button_id;
        in_item.button_down  = button_down;
        in_item.command_byte = command_byte;
        in_item.data_first   = data_first;
        in_item.data_second  = data_second;
        in_item.byte_count   = byte_count;
    end

    assign advance = item_valid && room;

    dbm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dbm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    dbm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign reply_first  = res_out.reply_first;
    assign reply_second = res_out.reply_second;
    assign reply_length = res_out.reply_length;
    assign data_pending = res_out.data_pending;
    assign bus_address  = res_out.bus_address;

endmodule

// ===== rtl/dbm_in_stage.sv =====
// Input register of the desktop-bus mouse: holds one accepted beat.
// Depends on dbm_pkg.
module dbm_in_stage
    import dbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    assign in_ready   = !valid_reg || advance;
    assign take       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_item;
    end

endmodule

// ===== rtl/dbm_core.sv =====
// Mouse state and the event/command logic.
// Depends on dbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dbm_core
    import dbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  in_item_t item,
    output result_t  res
);

    logic [1:0]         button_reg, button_next;
    logic [1:0]         reported_reg, reported_next;
    logic signed [15:0] motion_x_reg, motion_x_next;
    logic signed [15:0] motion_y_reg, motion_y_next;
    logic [3:0]         address_reg, address_next;
    logic [7:0]         handler_reg, handler_next;

    logic               pending_now;
    logic signed [15:0] cx, cy;
    logic [1:0]         kind;
    logic [1:0]         regnum;
    logic               is_flush, is_listen3, is_talk3, is_talk0;

    assign pending_now = (reported_reg != button_reg) || (motion_x_reg != '0)
                         || (motion_y_reg != '0);
    assign cx     = clamp63(motion_x_reg);
    assign cy     = clamp63(motion_y_reg);
    assign kind   = item.command_byte[3:2];
    assign regnum = item.command_byte[1:0];

    always_comb
    begin
        is_flush   = (item.opcode == OP_BUS) && (item.command_byte[3:0] == CMD_FLUSH);
        is_listen3 = (item.opcode == OP_BUS) && !is_flush && (kind == KIND_LISTEN)
                     && (regnum == REG_3);
        is_talk3   = (item.opcode == OP_BUS) && !is_flush && (kind == KIND_TALK)
                     && (regnum == REG_3);
        is_talk0   = (item.opcode == OP_BUS) && !is_flush && (kind == KIND_TALK)
                     && (regnum == REG_0);
    end

    always_comb
    begin
        button_next   = button_reg;
        reported_next = reported_reg;
        motion_x_next = motion_x_reg;
        motion_y_next = motion_y_reg;
        address_next  = address_reg;
        handler_next  = handler_reg;
        res.reply_first  = '0;
        res.reply_second = '0;
        res.reply_length = REPLY_NONE;

        case (item.opcode)
            OP_MOTION:
            begin
                if (item.axis == AXIS_X)
                    motion_x_next = sat_add16(motion_x_reg, item.move_value);
                else if (item.axis == AXIS_Y)
                    motion_y_next = sat_add16(motion_y_reg, item.move_value);
            end
            OP_BUTTON:
            begin
                if (item.button_id == BTN_LEFT)
                    button_next[0] = item.button_down;
                else if (item.button_id == BTN_RIGHT)
                    button_next[1] = item.button_down;
            end
            OP_BUS:
            begin
                if (is_flush)
                begin
                    button_next   = reported_reg;
                    motion_x_next = '0;
                    motion_y_next = '0;
                end
                else if (is_listen3)
                begin
                    if (item.byte_count == LISTEN_LEN && item.data_second != CODE_SELFTEST)
                    begin
                        address_next = item.data_first[3:0];
                        if (item.data_second inside {HANDLER_1, HANDLER_2})
                            handler_next = item.data_second;
                    end
                end
                else if (is_talk3)
                begin
                    res.reply_first  = {4'd0, address_reg};
                    res.reply_second = handler_reg;
                    res.reply_length = REPLY_TWO;
                end
                else if (is_talk0 && pending_now)
                begin
                    motion_x_next    = motion_x_reg - cx;
                    motion_y_next    = motion_y_reg - cy;
                    reported_next    = button_reg;
                    // bit 7 is the inverted button: 1 means released
                    res.reply_first  = {~button_reg[0], cy[6:0]};
                    res.reply_second = {~button_reg[1], cx[6:0]};
                    res.reply_length = REPLY_TWO;
                end
            end
            default:
            begin
            end
        endcase

        res.data_pending = (reported_next != button_next) || (motion_x_next != '0)
                           || (motion_y_next != '0);
        res.bus_address  = address_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_reg   <= '0;
            reported_reg <= '0;
            motion_x_reg <= '0;
            motion_y_reg <= '0;
            address_reg  <= RESET_ADDRESS;
            handler_reg  <= RESET_HANDLER;
        end
        else if (advance)
        begin
            button_reg   <= button_next;
            reported_reg <= reported_next;
            motion_x_reg <= motion_x_next;
            motion_y_reg <= motion_y_next;
            address_reg  <= address_next;
            handler_reg  <= handler_next;
        end
    end

    `DBM_ASSERT(a_flush_clears,
        advance && is_flush |=> motion_x_reg == '0 && motion_y_reg == '0,
        "flush left motion behind")
    `DBM_ASSERT(a_talk0_syncs,
        advance && is_talk0 && pending_now |=> reported_reg == button_reg,
        "talk 0 did not latch buttons")
    `DBM_ASSERT(a_idle_holds,
        !advance |=> $stable(address_reg) && $stable(handler_reg) && $stable(button_reg),
        "state moved without a beat")
    `DBM_ASSERT(a_handler_legal,
        handler_reg == HANDLER_1 || handler_reg == HANDLER_2,
        "handler outside 1..2")

endmodule

// ===== rtl/dbm_out_stage.sv =====
// Result register of the desktop-bus mouse: one result beat waiting for the sink.
// Depends on dbm_pkg.
module dbm_out_stage
    import dbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

endmodule
